### sv/rxrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Receive ring buffer package
// Shared types and constants for the receive ring buffer line reader.
// ----------------------------------------------------------------------------
package rxrb_pkg;

   localparam int BYTE_W  = 8;
   localparam int FILL_W  = 6;
   localparam int LIMIT_W = 7;

   localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

   typedef enum logic [1:0] {
      CMD_STORE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_COUNT = 2'd2,
      CMD_LINE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LINE,
      ST_FETCH_ONE,
      ST_FETCH_LINE,
      ST_TERM
   } state_type;

   typedef enum logic [1:0] {
      RSP_STATUS,
      RSP_BYTE_LAST,
      RSP_BYTE_MORE,
      RSP_TERM
   } rsp_sel_type;

   typedef struct packed {
      logic        ram_write;
      logic        pop;
      logic        rsp_load;
      rsp_sel_type rsp_sel;
      logic        rsp_acc;
      logic        line_start;
      logic        taken_inc;
   } ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic line_more;
      logic rd_zero;
      logic rd_eol;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

### sv/rxrb_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Receive ring buffer channels
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface rxrb_req_if;
   import rxrb_pkg::*;

   logic                 valid;
   logic                 ready;
   cmd_type              cmd;
   logic [BYTE_W-1:0]    data_byte;
   logic [LIMIT_W-1:0]   line_limit;

   modport source (output valid, cmd, data_byte, line_limit, input ready);
   modport sink (input valid, cmd, data_byte, line_limit, output ready);
endinterface

interface rxrb_rsp_if;
   import rxrb_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [BYTE_W-1:0]    out_byte;
   logic [FILL_W-1:0]    fill_count;
   logic                 accepted;
   logic                 last;

   modport source (output valid, out_byte, fill_count, accepted, last, input ready);
   modport sink (input valid, out_byte, fill_count, accepted, last, output ready);
endinterface
`default_nettype wire

### sv/rxrb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module rxrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### sv/rxrb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Receive ring buffer controller
// Sequences commands and line reads and drives the datapath.
// ----------------------------------------------------------------------------
module rxrb_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire rxrb_pkg::cmd_type    req_cmd,
   output      logic                 req_ready,
   input  wire rxrb_pkg::status_type status,
   output      rxrb_pkg::ctl_type    ctl
);
   import rxrb_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      take;

   assign take = req_valid && status.out_free && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (req_cmd == CMD_READ && !status.empty) begin
                  state_in = ST_FETCH_ONE;
               end else if (req_cmd == CMD_LINE) begin
                  state_in = ST_LINE;
               end
            end
         end
         ST_LINE: begin
            if (status.out_free) begin
               if (status.line_more && !status.empty) begin
                  state_in = ST_FETCH_LINE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FETCH_ONE: begin
            state_in = ST_IDLE;
         end
         ST_FETCH_LINE: begin
            if (status.rd_zero) begin
               state_in = ST_IDLE;
            end else if (status.rd_eol) begin
               state_in = ST_TERM;
            end else begin
               state_in = ST_LINE;
            end
         end
         ST_TERM: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl       = '0;
      ctl.rsp_sel = RSP_STATUS;
      req_ready = (state_ff == ST_IDLE) && status.out_free;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               unique case (req_cmd)
                  CMD_STORE: begin
                     ctl.ram_write = !status.full;
                     ctl.rsp_load  = 1'b1;
                     ctl.rsp_acc   = !status.full;
                  end
                  CMD_READ: begin
                     ctl.pop      = !status.empty;
                     ctl.rsp_load = status.empty;
                  end
                  CMD_COUNT: begin
                     ctl.rsp_load = 1'b1;
                  end
                  CMD_LINE: begin
                     ctl.line_start = 1'b1;
                  end
                  default: ctl.rsp_load = 1'b1;
               endcase
            end
         end
         ST_LINE: begin
            if (status.out_free) begin
               if (status.line_more && !status.empty) begin
                  ctl.pop = 1'b1;
               end else begin
                  ctl.rsp_load = 1'b1;
                  ctl.rsp_sel  = RSP_TERM;
               end
            end
         end
         ST_FETCH_ONE: begin
            ctl.rsp_load = 1'b1;
            ctl.rsp_sel  = RSP_BYTE_LAST;
         end
         ST_FETCH_LINE: begin
            ctl.rsp_load = 1'b1;
            if (status.rd_zero) begin
               ctl.rsp_sel = RSP_TERM;
            end else begin
               ctl.rsp_sel   = RSP_BYTE_MORE;
               ctl.taken_inc = 1'b1;
            end
         end
         ST_TERM: begin
            if (status.out_free) begin
               ctl.rsp_load = 1'b1;
               ctl.rsp_sel  = RSP_TERM;
            end
         end
         default: ctl = '0;
      endcase
   end
endmodule
`default_nettype wire

### sv/rxrb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Receive ring buffer datapath
// Pointers, byte store, line counters and the response register.
// ----------------------------------------------------------------------------
module rxrb_datapath #(
   parameter int DEPTH    = 64,
   parameter int MAX_LINE = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire rxrb_pkg::ctl_type               ctl,
   output      rxrb_pkg::status_type            status,
   input  wire logic [rxrb_pkg::BYTE_W-1:0]     req_data_byte,
   input  wire logic [rxrb_pkg::LIMIT_W-1:0]    req_line_limit,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [rxrb_pkg::BYTE_W-1:0]     rsp_out_byte,
   output      logic [rxrb_pkg::FILL_W-1:0]     rsp_fill_count,
   output      logic                            rsp_accepted,
   output      logic                            rsp_last
);
   import rxrb_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = (PW + 1 > FILL_W) ? PW + 1 : FILL_W;
   localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

   logic [PW-1:0]      wp_ff, wp_in, wp_inc;
   logic [PW-1:0]      rp_ff, rp_in, rp_inc;
   logic [LIMIT_W-1:0] lim_ff, lim_in;
   logic [LIMIT_W-1:0] taken_ff, taken_in;
   logic [BYTE_W-1:0]  rd_data;
   logic [CW-1:0]      fill;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [FILL_W-1:0] fillc_ff, fillc_in;
   logic              acc_ff, acc_in;
   logic              last_ff, last_in;

   rxrb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ctl.ram_write),
      .wr_addr (wp_ff),
      .wr_data (req_data_byte),
      .rd_en   (ctl.pop),
      .rd_addr (rp_ff),
      .rd_data (rd_data)
   );

   assign wp_inc = (wp_ff == LAST_IDX) ? '0 : wp_ff + PW'(1);
   assign rp_inc = (rp_ff == LAST_IDX) ? '0 : rp_ff + PW'(1);
   assign wp_in  = ctl.ram_write ? wp_inc : wp_ff;
   assign rp_in  = ctl.pop ? rp_inc : rp_ff;

   assign fill = CW'(wp_in) - CW'(rp_in) + ((wp_in < rp_in) ? CW'(DEPTH) : CW'(0));

   always_comb begin
      lim_in   = lim_ff;
      taken_in = taken_ff;
      if (ctl.line_start) begin
         lim_in   = (req_line_limit > LIMIT_W'(MAX_LINE)) ? LIMIT_W'(MAX_LINE)
                                                          : req_line_limit;
         taken_in = '0;
      end else if (ctl.taken_inc) begin
         taken_in = taken_ff + LIMIT_W'(1);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      fillc_in = fillc_ff;
      acc_in   = acc_ff;
      last_in  = last_ff;
      if (ctl.rsp_load) begin
         valid_in = 1'b1;
         fillc_in = fill[FILL_W-1:0];
         acc_in   = ctl.rsp_acc;
         unique case (ctl.rsp_sel)
            RSP_STATUS: begin
               byte_in = CH_NUL;
               last_in = 1'b1;
            end
            RSP_BYTE_LAST: begin
               byte_in = rd_data;
               last_in = 1'b1;
            end
            RSP_BYTE_MORE: begin
               byte_in = rd_data;
               last_in = 1'b0;
            end
            RSP_TERM: begin
               byte_in = CH_NUL;
               last_in = 1'b1;
            end
            default: begin
               byte_in = CH_NUL;
               last_in = 1'b1;
            end
         endcase
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff   <= lim_in;
      taken_ff <= taken_in;
      byte_ff  <= byte_in;
      fillc_ff <= fillc_in;
      acc_ff   <= acc_in;
      last_ff  <= last_in;
   end

   assign status.empty     = (wp_ff == rp_ff);
   assign status.full      = (wp_inc == rp_ff);
   assign status.line_more = (taken_ff + LIMIT_W'(1)) < lim_ff;
   assign status.rd_zero   = (rd_data == CH_NUL);
   assign status.rd_eol    = (rd_data == CH_CR) || (rd_data == CH_LF);
   assign status.out_free  = !valid_ff || rsp_ready;

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_fill_count = fillc_ff;
   assign rsp_accepted   = acc_ff;
   assign rsp_last       = last_ff;
endmodule
`default_nettype wire

### sv/rx_ring_buffer_line_reader.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Receive ring buffer line reader
// Circular byte buffer with store, single-byte read, fill query and line read.
// ----------------------------------------------------------------------------
// The buffer holds up to DEPTH-1 bytes in a RAM with registered read data.
// Store, fill-count query and a read of an empty buffer are answered from
// the idle state, so such words can be accepted every cycle while the
// response consumer keeps up. A single-byte read from a non-empty buffer
// passes through a fetch state because the RAM read data is registered. A
// line read produces one response word per popped byte other than a zero
// byte, plus a terminator. The line read loops between a pop state and a
// fetch state around the RAM read port; no request word is accepted until
// its terminator is loaded. Responses carry the fill count modulo 64 after
// the action that produced them.
// ----------------------------------------------------------------------------
module rx_ring_buffer_line_reader #(
   parameter int DEPTH    = 64,
   parameter int MAX_LINE = 64
) (
   input wire logic clock,
   input wire logic reset,
   rxrb_req_if.sink   req,
   rxrb_rsp_if.source rsp
);
   import rxrb_pkg::*;

   ctl_type    ctl;
   status_type status;

   rxrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_cmd   (req.cmd),
      .req_ready (req.ready),
      .status    (status),
      .ctl       (ctl)
   );

   rxrb_datapath #(
      .DEPTH    (DEPTH),
      .MAX_LINE (MAX_LINE)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .status         (status),
      .req_data_byte  (req.data_byte),
      .req_line_limit (req.line_limit),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .rsp_out_byte   (rsp.out_byte),
      .rsp_fill_count (rsp.fill_count),
      .rsp_accepted   (rsp.accepted),
      .rsp_last       (rsp.last)
   );
endmodule
`default_nettype wire

### sim/tb_rx_ring_buffer_line_reader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receive ring buffer line reader testbench
// Drives store, read, fill-count and line-read words into the block and
// checks every response word against a behavioral ring buffer kept here.
// Both channels idle at random, and the response side holds off once for a
// long stretch so that the block backs up and stalls its request channel.
// ----------------------------------------------------------------------------
module tb_rx_ring_buffer_line_reader;
   import rxrb_pkg::*;

   localparam int MAX_LINE_LEN = 64;
   localparam int RING_SLOTS   = 64;
   localparam int LONG_HOLD    = 300;
   localparam int TAIL_CYCLES  = 20;

   localparam int F_NONE  = 0;
   localparam int F_DRAIN = 1;
   localparam int F_HOLD  = 2;
   localparam int F_BURST = 4;

   typedef struct packed {
      cmd_type            cmd;
      logic [BYTE_W-1:0]  data;
      logic [LIMIT_W-1:0] limit;
      logic               drain;
      logic               hold;
      logic               burst;
   } req_word_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [FILL_W-1:0] fill;
      logic              accepted;
      logic              last;
   } rsp_word_type;

   logic clock;
   logic reset;

   rxrb_req_if req_ch ();
   rxrb_rsp_if rsp_ch ();

   rx_ring_buffer_line_reader dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   req_word_type req_words_todo[$];
   rsp_word_type rsp_words_due[$];

   logic [BYTE_W-1:0] ring_mem [RING_SLOTS];
   logic [FILL_W-1:0] wr_ptr = '0;
   logic [FILL_W-1:0] rd_ptr = '0;

   int  mismatch_count = 0;
   bit  rx_hold_req;
   bit  hold_done = 1'b0;
   int  send_gap;
   bit  offer;
   int  stall_left = 0;
   int  calm_left = 0;
   req_word_type cur_word;
   rsp_word_type want;

   function automatic void queue_word(cmd_type c, int d, int l, int flags);
      req_word_type w;
      w.cmd   = c;
      w.data  = d[BYTE_W-1:0];
      w.limit = l[LIMIT_W-1:0];
      w.drain = (flags & F_DRAIN) != 0;
      w.hold  = (flags & F_HOLD) != 0;
      w.burst = (flags & F_BURST) != 0;
      req_words_todo.push_back(w);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int text_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(8'h20, 8'h7E);
      if (r < 90) return CH_CR;
      if (r < 95) return CH_LF;
      return CH_NUL;
   endfunction

   function automatic int line_limit_pick();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return $urandom_range(0, 1);
      if (r < 80) return $urandom_range(2, MAX_LINE_LEN);
      return $urandom_range(MAX_LINE_LEN + 1, 127);
   endfunction

   function automatic void apply_ring_command(req_word_type w);
      rsp_word_type r;
      int lim;
      int taken;
      logic [BYTE_W-1:0] b;
      bit stop;
      r = '0;
      case (w.cmd)
         CMD_STORE: begin
            if (wr_ptr + 6'd1 != rd_ptr) begin
               ring_mem[wr_ptr] = w.data;
               wr_ptr = wr_ptr + 6'd1;
               r.accepted = 1'b1;
            end
         end
         CMD_READ: begin
            if (wr_ptr != rd_ptr) begin
               r.out_byte = ring_mem[rd_ptr];
               rd_ptr = rd_ptr + 6'd1;
            end
         end
         CMD_LINE: begin
            lim = (int'(w.limit) > MAX_LINE_LEN) ? MAX_LINE_LEN : int'(w.limit);
            taken = 0;
            stop = 1'b0;
            while (!stop && taken < lim - 1 && wr_ptr != rd_ptr) begin
               b = ring_mem[rd_ptr];
               rd_ptr = rd_ptr + 6'd1;
               if (b == CH_NUL) begin
                  stop = 1'b1;
               end else begin
                  r.out_byte = b;
                  r.fill = wr_ptr - rd_ptr;
                  r.last = 1'b0;
                  rsp_words_due.push_back(r);
                  taken++;
                  if (b == CH_CR || b == CH_LF) stop = 1'b1;
               end
            end
            r.out_byte = CH_NUL;
         end
         default: begin
         end
      endcase
      r.fill = wr_ptr - rd_ptr;
      r.last = 1'b1;
      rsp_words_due.push_back(r);
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         offer = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            apply_ring_command(cur_word);
            offer = 1'b0;
            send_gap = cur_word.burst ? 0 : pick_gap();
         end
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
            end else if (req_words_todo.size() > 0 &&
                         !(req_words_todo[0].drain && rsp_words_due.size() > 0)) begin
               cur_word = req_words_todo.pop_front();
               req_ch.cmd <= cur_word.cmd;
               req_ch.data_byte <= cur_word.data;
               req_ch.line_limit <= cur_word.limit;
               if (cur_word.hold) rx_hold_req <= 1'b1;
               offer = 1'b1;
            end
         end
         req_ch.valid <= offer;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (rsp_words_due.size() == 0) begin
               $display("%0t: unexpected word: byte=%h fill=%0d accepted=%b last=%b",
                        $time, rsp_ch.out_byte, rsp_ch.fill_count, rsp_ch.accepted,
                        rsp_ch.last);
               mismatch_count++;
            end else begin
               want = rsp_words_due.pop_front();
               if (rsp_ch.out_byte !== want.out_byte || rsp_ch.fill_count !== want.fill ||
                   rsp_ch.accepted !== want.accepted || rsp_ch.last !== want.last) begin
                  $display("%0t: mismatch: expected byte=%h fill=%0d accepted=%b last=%b",
                           $time, want.out_byte, want.fill, want.accepted, want.last);
                  $display("%0t:           actual   byte=%h fill=%0d accepted=%b last=%b",
                           $time, rsp_ch.out_byte, rsp_ch.fill_count, rsp_ch.accepted,
                           rsp_ch.last);
                  mismatch_count++;
               end
            end
         end
         if (rx_hold_req && !hold_done) begin
            stall_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
            case ($urandom_range(0, 9))
               0, 1: stall_left = pick_gap();
               2: calm_left = $urandom_range(20, 60);
               default: begin
               end
            endcase
         end
      end
   end

   initial begin
      #50_000_000;
      $display("rx_ring_buffer_line_reader test failed");
      $finish;
   end

   initial begin
      int n;
      int k;
      int flags;
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_STORE;
      req_ch.data_byte = '0;
      req_ch.line_limit = '0;
      rsp_ch.ready = 1'b0;
      rx_hold_req = 1'b0;
      reset = 1'b1;

      queue_word(CMD_COUNT, 8'hA5, 0, F_NONE);
      queue_word(CMD_READ, 8'h5A, 0, F_NONE);
      queue_word(CMD_LINE, 8'hFF, 5, F_NONE);
      queue_word(CMD_STORE, 8'h00, 127, F_NONE);
      queue_word(CMD_STORE, 8'hFF, 0, F_NONE);
      queue_word(CMD_STORE, CH_CR, 0, F_NONE);
      queue_word(CMD_STORE, 8'h41, 0, F_NONE);
      queue_word(CMD_STORE, CH_LF, 0, F_NONE);
      queue_word(CMD_COUNT, 8'h00, 127, F_NONE);
      queue_word(CMD_READ, 8'h00, 0, F_NONE);
      queue_word(CMD_LINE, 8'h00, 0, F_NONE);
      queue_word(CMD_LINE, 8'h00, 1, F_NONE);
      queue_word(CMD_LINE, 8'hFF, 127, F_NONE);
      queue_word(CMD_LINE, 8'h00, 2, F_NONE);
      queue_word(CMD_READ, 8'hFF, 127, F_NONE);
      queue_word(CMD_STORE, 8'h55, 0, F_NONE);
      queue_word(CMD_STORE, 8'h42, 0, F_NONE);
      queue_word(CMD_STORE, 8'h00, 0, F_NONE);
      queue_word(CMD_STORE, 8'h43, 0, F_NONE);
      queue_word(CMD_LINE, 8'h00, 64, F_NONE);
      queue_word(CMD_LINE, 8'h00, 3, F_NONE);

      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            queue_word(CMD_COUNT, 0, 0, F_DRAIN | F_HOLD);
            for (int i = 0; i < 65; i++)
               queue_word(CMD_STORE, $urandom_range(8'h20, 8'h7E), $urandom_range(0, 127),
                          F_BURST);
            queue_word(CMD_COUNT, 0, 0, F_DRAIN);
            for (int i = 0; i < 3; i++)
               queue_word(CMD_LINE, $urandom_range(0, 255), MAX_LINE_LEN, F_NONE);
            queue_word(CMD_READ, 0, 0, F_NONE);
         end else begin
            n = 0;
            while (n < (phase == 0 ? 10 : 4)) begin
               flags = ($urandom_range(0, 9) < 3) ? F_BURST : F_NONE;
               if ($urandom_range(0, 9) < 7) begin
                  k = $urandom_range(1, 12);
                  for (int i = 0; i < k; i++)
                     queue_word(CMD_STORE, text_byte(), $urandom_range(0, 127), flags);
                  if ($urandom_range(0, 1) == 1)
                     queue_word(CMD_STORE, $urandom_range(0, 1) ? CH_CR : CH_LF, 0, flags);
                  queue_word(CMD_LINE, $urandom_range(0, 255), line_limit_pick(), flags);
                  n += k + 2;
                  if ($urandom_range(0, 9) < 3) begin
                     queue_word($urandom_range(0, 1) ? CMD_READ : CMD_COUNT,
                                $urandom_range(0, 255), $urandom_range(0, 127), flags);
                     n++;
                  end
               end else begin
                  queue_word(cmd_type'($urandom_range(0, 3)), $urandom_range(0, 255),
                             $urandom_range(0, 127), flags);
                  n++;
               end
            end
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (!(req_words_todo.size() == 0 && !req_ch.valid && rsp_words_due.size() == 0))
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("rx_ring_buffer_line_reader test passed");
      end else begin
         $display("rx_ring_buffer_line_reader test failed");
      end
      $finish;
   end

endmodule

### sim.f
sv/rxrb_pkg.sv
sv/rxrb_if.sv
sv/rxrb_ram.sv
sv/rxrb_ctrl.sv
sv/rxrb_datapath.sv
sv/rx_ring_buffer_line_reader.sv
sim/tb_rx_ring_buffer_line_reader.sv
